### rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Each use names its own label.
// The clock is clk and the reset is rst_n, active low, in every user.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

### rtl/qapce_pkg.sv
package qapce_pkg;

  // Instance limits and field widths.
  localparam int MAX_SIZE = 32;
  localparam int IDX_W    = $clog2(MAX_SIZE);
  localparam int SIZE_W   = IDX_W + 1;
  localparam int ADDR_W   = 2 * IDX_W;
  localparam int DEPTH    = MAX_SIZE * MAX_SIZE;
  localparam int KIND_W   = 3;
  localparam int VAL_W    = 16;
  localparam int PROD_W   = 2 * VAL_W;
  localparam int COST_W   = 42;

  // Operation codes carried in the kind field.
  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD_DIST = 3'd0,
    KIND_LOAD_FLOW = 3'd1,
    KIND_IDENTITY  = 3'd2,
    KIND_SWAP      = 3'd3,
    KIND_ASSIGN    = 3'd4,
    KIND_EVAL      = 3'd5
  } kind_t;

  // Result status codes.
  localparam logic STATUS_DONE    = 1'b0;
  localparam logic STATUS_IGNORED = 1'b1;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_ASSIGN_RD,
    ST_SWAP_WR1,
    ST_SWAP_WR2,
    ST_EVAL,
    ST_DRAIN,
    ST_FINISH
  } state_t;

endpackage

### rtl/qapce_if.sv
// Input word channel: one operation per word.
interface qapce_in_if;
  logic                          valid;
  logic                          ready;
  logic [qapce_pkg::KIND_W-1:0]  kind;
  logic [qapce_pkg::IDX_W-1:0]   first_index;
  logic [qapce_pkg::IDX_W-1:0]   second_index;
  logic [qapce_pkg::VAL_W-1:0]   entry_value;

  modport source (output valid, kind, first_index, second_index, entry_value,
                  input ready);
  modport sink   (input valid, kind, first_index, second_index, entry_value,
                  output ready);
endinterface

// Result word channel: one result per input word.
interface qapce_out_if;
  logic                          valid;
  logic                          ready;
  logic                          status;
  logic [qapce_pkg::COST_W-1:0]  total_cost;

  modport source (output valid, status, total_cost, input ready);
  modport sink   (input valid, status, total_cost, output ready);
endinterface

### rtl/qap_permutation_cost_engine.sv
// Channel   | Dir | Handshake     | Word
// ----------+-----+---------------+------------------------------------------
// in_chan   | in  | valid/ready   | kind, first_index, second_index, value
// out_chan  | out | valid/ready   | status, total_cost
// cfg_*     | in  | write enable  | size_in_use (6 bits)
//
// Loads, identity and rejected words pass DECODE and FINISH to the result.
// Swap adds the SWAP_WR1 and SWAP_WR2 steps and assign adds ASSIGN_RD first,
// set by the one write port of the permutation and inverse memories (two entries of each change).
// Evaluate reads one product per cycle from the distance and flow memories
// over n*n entries, then drains the read, multiply and accumulate pipeline.
// Reset is synchronous; permutations read as identity through valid bits.
// A new word is accepted while a finished result waits; a result stalls only
// at the finish step when the output register is still full.
`include "assert_macros.svh"

module qap_permutation_cost_engine (
  input  logic                          clk,
  input  logic                          rst_n,
  qapce_in_if.sink                      in_chan,
  qapce_out_if.source                   out_chan,
  input  logic                          cfg_wr_en,
  input  logic [qapce_pkg::SIZE_W-1:0]  cfg_wr_data
);

  localparam int IW = qapce_pkg::IDX_W;
  localparam int SW = qapce_pkg::SIZE_W;
  localparam int AW = qapce_pkg::ADDR_W;
  localparam int VW = qapce_pkg::VAL_W;
  localparam int PW = qapce_pkg::PROD_W;
  localparam int CW = qapce_pkg::COST_W;
  localparam int MS = qapce_pkg::MAX_SIZE;

  // Storage.
  logic [VW-1:0] dist_mem [qapce_pkg::DEPTH];
  logic [VW-1:0] flow_mem [qapce_pkg::DEPTH];
  logic [IW-1:0] perm_mem [MS];
  logic [IW-1:0] inv_mem  [MS];

  qapce_pkg::state_t state_r, state_nxt;

  logic [SW-1:0] size_r;
  logic [SW-1:0] n_eff;
  logic [IW-1:0] n_m1;

  logic [qapce_pkg::KIND_W-1:0] kind_r;
  logic [IW-1:0] a_r, b_r, b_nxt;
  logic [VW-1:0] val_r;
  logic          status_r, status_nxt;
  logic [IW-1:0] va_r, vb_r;

  logic [MS-1:0] perm_vld_r, inv_vld_r;

  // Memory control.
  logic          perm_we, inv_we, dist_we, flow_we, clr_perm;
  logic [IW-1:0] perm_waddr, perm_wdata, inv_waddr, inv_wdata;
  logic [IW-1:0] perm_raddr_a, perm_raddr_b, inv_raddr;
  logic [IW-1:0] perm_rd_a_r, perm_rd_b_r, inv_rd_r;
  logic [IW-1:0] perm_raddr_a_r, perm_raddr_b_r, inv_raddr_r;
  logic          perm_va_vld_r, perm_vb_vld_r, inv_v_vld_r;
  logic [IW-1:0] pa_res, pb_res, inv_res;

  // Evaluation pipeline.
  logic          eval_start, issue, eval_last;
  logic [IW-1:0] i_r, j_r, i_d1_r, j_d1_r;
  logic          s1_vld_r, s2_vld_r, s3_vld_r;
  logic [VW-1:0] dist_rd_r, flow_rd_r;
  logic [PW-1:0] prod_r;
  logic [CW-1:0] acc_r;
  logic [CW:0]   acc_sum;

  // Output register.
  logic          out_valid_r, out_status_r;
  logic [CW-1:0] out_cost_r;
  logic          finish;

  logic in_acc;
  logic a_bad, b_bad;

  assign in_chan.ready     = (state_r == qapce_pkg::ST_IDLE);
  assign in_acc            = in_chan.valid && in_chan.ready;
  assign out_chan.valid    = out_valid_r;
  assign out_chan.status   = out_status_r;
  assign out_chan.total_cost = out_cost_r;

  // Clamp the configured size into 1..MAX_SIZE.
  always_comb begin
    if (size_r == '0) begin
      n_eff = SW'(1);
    end else if (size_r > SW'(MS)) begin
      n_eff = SW'(MS);
    end else begin
      n_eff = size_r;
    end
  end
  assign n_m1  = IW'(n_eff - SW'(1));
  assign a_bad = ({1'b0, a_r} >= n_eff);
  assign b_bad = ({1'b0, b_r} >= n_eff);

  // Permutation reads resolve to identity for entries not written since reset.
  assign pa_res  = perm_va_vld_r ? perm_rd_a_r : perm_raddr_a_r;
  assign pb_res  = perm_vb_vld_r ? perm_rd_b_r : perm_raddr_b_r;
  assign inv_res = inv_v_vld_r   ? inv_rd_r    : inv_raddr_r;

  assign eval_last = (i_r == n_m1) && (j_r == n_m1);

  // Next state and memory control.
  always_comb begin
    state_nxt    = state_r;
    status_nxt   = status_r;
    b_nxt        = b_r;
    perm_we      = 1'b0;
    inv_we       = 1'b0;
    dist_we      = 1'b0;
    flow_we      = 1'b0;
    clr_perm     = 1'b0;
    perm_waddr   = a_r;
    perm_wdata   = pb_res;
    inv_waddr    = pa_res;
    inv_wdata    = b_r;
    perm_raddr_a = a_r;
    perm_raddr_b = b_r;
    inv_raddr    = b_r;
    eval_start   = 1'b0;
    issue        = 1'b0;
    finish       = 1'b0;
    unique case (state_r)
      qapce_pkg::ST_IDLE: begin
        if (in_acc) begin
          status_nxt = qapce_pkg::STATUS_DONE;
          state_nxt  = qapce_pkg::ST_DECODE;
        end
      end
      qapce_pkg::ST_DECODE: begin
        unique case (kind_r) inside
          qapce_pkg::KIND_LOAD_DIST, qapce_pkg::KIND_LOAD_FLOW: begin
            if (a_bad || b_bad) begin
              status_nxt = qapce_pkg::STATUS_IGNORED;
            end else if (kind_r == qapce_pkg::KIND_LOAD_DIST) begin
              dist_we = 1'b1;
            end else begin
              flow_we = 1'b1;
            end
            state_nxt = qapce_pkg::ST_FINISH;
          end
          qapce_pkg::KIND_IDENTITY: begin
            clr_perm  = 1'b1;
            state_nxt = qapce_pkg::ST_FINISH;
          end
          qapce_pkg::KIND_SWAP: begin
            if (a_bad || b_bad) begin
              status_nxt = qapce_pkg::STATUS_IGNORED;
              state_nxt  = qapce_pkg::ST_FINISH;
            end else begin
              state_nxt = qapce_pkg::ST_SWAP_WR1;
            end
          end
          qapce_pkg::KIND_ASSIGN: begin
            if (a_bad || b_bad) begin
              status_nxt = qapce_pkg::STATUS_IGNORED;
              state_nxt  = qapce_pkg::ST_FINISH;
            end else begin
              state_nxt = qapce_pkg::ST_ASSIGN_RD;
            end
          end
          qapce_pkg::KIND_EVAL: begin
            eval_start = 1'b1;
            state_nxt  = qapce_pkg::ST_EVAL;
          end
          default: begin
            status_nxt = qapce_pkg::STATUS_IGNORED;
            state_nxt  = qapce_pkg::ST_FINISH;
          end
        endcase
      end
      qapce_pkg::ST_ASSIGN_RD: begin
        // The position that holds the value becomes the swap partner.
        b_nxt        = inv_res;
        perm_raddr_b = inv_res;
        state_nxt    = qapce_pkg::ST_SWAP_WR1;
      end
      qapce_pkg::ST_SWAP_WR1: begin
        perm_we   = 1'b1;
        inv_we    = 1'b1;
        state_nxt = qapce_pkg::ST_SWAP_WR2;
      end
      qapce_pkg::ST_SWAP_WR2: begin
        perm_we    = 1'b1;
        inv_we     = 1'b1;
        perm_waddr = b_r;
        perm_wdata = va_r;
        inv_waddr  = vb_r;
        inv_wdata  = a_r;
        state_nxt  = qapce_pkg::ST_FINISH;
      end
      qapce_pkg::ST_EVAL: begin
        issue        = 1'b1;
        perm_raddr_a = i_r;
        perm_raddr_b = j_r;
        if (eval_last) begin
          state_nxt = qapce_pkg::ST_DRAIN;
        end
      end
      qapce_pkg::ST_DRAIN: begin
        if (!s1_vld_r && !s2_vld_r && !s3_vld_r) begin
          state_nxt = qapce_pkg::ST_FINISH;
        end
      end
      qapce_pkg::ST_FINISH: begin
        if (!out_valid_r || out_chan.ready) begin
          finish    = 1'b1;
          state_nxt = qapce_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = qapce_pkg::ST_IDLE;
      end
    endcase
  end

  // State, configuration and valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= qapce_pkg::ST_IDLE;
      size_r     <= SW'(MS);
      perm_vld_r <= '0;
      inv_vld_r  <= '0;
      status_r   <= qapce_pkg::STATUS_DONE;
    end else begin
      state_r  <= state_nxt;
      status_r <= status_nxt;
      if (cfg_wr_en) begin
        size_r <= cfg_wr_data;
      end
      if (clr_perm) begin
        perm_vld_r <= '0;
        inv_vld_r  <= '0;
      end else begin
        if (perm_we) begin
          perm_vld_r[perm_waddr] <= 1'b1;
        end
        if (inv_we) begin
          inv_vld_r[inv_waddr] <= 1'b1;
        end
      end
    end
  end

  // Accepted word and swap operands.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r <= in_chan.kind;
      a_r    <= in_chan.first_index;
      val_r  <= in_chan.entry_value;
    end
    if (in_acc) begin
      b_r <= in_chan.second_index;
    end else begin
      b_r <= b_nxt;
    end
    if (state_r == qapce_pkg::ST_SWAP_WR1) begin
      va_r <= pa_res;
      vb_r <= pb_res;
    end
  end

  // Permutation and inverse memories: one write, registered reads.
  always_ff @(posedge clk) begin
    if (perm_we) begin
      perm_mem[perm_waddr] <= perm_wdata;
    end
    if (inv_we) begin
      inv_mem[inv_waddr] <= inv_wdata;
    end
    perm_rd_a_r    <= perm_mem[perm_raddr_a];
    perm_rd_b_r    <= perm_mem[perm_raddr_b];
    inv_rd_r       <= inv_mem[inv_raddr];
    perm_raddr_a_r <= perm_raddr_a;
    perm_raddr_b_r <= perm_raddr_b;
    inv_raddr_r    <= inv_raddr;
    perm_va_vld_r  <= perm_vld_r[perm_raddr_a];
    perm_vb_vld_r  <= perm_vld_r[perm_raddr_b];
    inv_v_vld_r    <= inv_vld_r[inv_raddr];
  end

  // Distance and flow memories: loads write, evaluation reads.
  always_ff @(posedge clk) begin
    if (dist_we) begin
      dist_mem[{a_r, b_r}] <= val_r;
    end
    if (flow_we) begin
      flow_mem[{a_r, b_r}] <= val_r;
    end
    dist_rd_r <= dist_mem[{i_d1_r, j_d1_r}];
    flow_rd_r <= flow_mem[AW'({pa_res, pb_res})];
  end

  // Evaluation counters and pipeline valids.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= issue;
      s2_vld_r <= s1_vld_r;
      s3_vld_r <= s2_vld_r;
    end
    if (eval_start) begin
      i_r <= '0;
      j_r <= '0;
    end else if (issue) begin
      if (j_r == n_m1) begin
        j_r <= '0;
        i_r <= i_r + IW'(1);
      end else begin
        j_r <= j_r + IW'(1);
      end
    end
    i_d1_r <= i_r;
    j_d1_r <= j_r;
  end

  // Multiply, then accumulate with saturation at the top of the cost range.
  assign acc_sum = {1'b0, acc_r} + (CW + 1)'(prod_r);

  always_ff @(posedge clk) begin
    if (s2_vld_r) begin
      prod_r <= dist_rd_r * flow_rd_r;
    end
    if (eval_start) begin
      acc_r <= '0;
    end else if (s3_vld_r) begin
      acc_r <= acc_sum[CW] ? {CW{1'b1}} : acc_sum[CW-1:0];
    end
  end

  // Result word register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (finish) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
    if (finish) begin
      out_status_r <= status_r;
      out_cost_r   <= (kind_r == qapce_pkg::KIND_EVAL) ? acc_r : '0;
    end
  end

  // Checks on the sequencer and datapath.
  `ASSERT_SAME(a_acc_in_eval, s3_vld_r,
    state_r == qapce_pkg::ST_EVAL || state_r == qapce_pkg::ST_DRAIN)
  `ASSERT_NEXT(a_finish_holds,
    state_r == qapce_pkg::ST_FINISH && out_valid_r && !out_chan.ready,
    state_r == qapce_pkg::ST_FINISH)
  `ASSERT_SAME(a_ignored_zero, out_valid_r && out_status_r, out_cost_r == '0)
  `ASSERT_SAME(a_col_in_range, state_r == qapce_pkg::ST_EVAL, {1'b0, j_r} < n_eff)
  `ASSERT_NEXT(a_swap_two_writes, state_r == qapce_pkg::ST_SWAP_WR1,
    state_r == qapce_pkg::ST_SWAP_WR2)

endmodule

### test/tb_qap_permutation_cost_engine.sv
`timescale 1ns / 1ps

module tb_qap_permutation_cost_engine;

  // Widths and limits taken from the package.
  localparam int MAX_SIZE = qapce_pkg::MAX_SIZE;
  localparam int KIND_W   = qapce_pkg::KIND_W;
  localparam int IDX_W    = qapce_pkg::IDX_W;
  localparam int SIZE_W   = qapce_pkg::SIZE_W;
  localparam int VAL_W    = qapce_pkg::VAL_W;
  localparam int COST_W   = qapce_pkg::COST_W;

  // Kinds outside the enum that the block must reject.
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  localparam int CYCLE_LIMIT  = 1_000_000;
  localparam int DRAIN_CYCLES = MAX_SIZE * MAX_SIZE + 64;
  localparam int HOLD_CYCLES  = 500;
  localparam int PHASE_WORDS  = 45;
  localparam int REPORT_MAX   = 10;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [IDX_W-1:0]  first_index;
    logic [IDX_W-1:0]  second_index;
    logic [VAL_W-1:0]  entry_value;
  } op_word_t;

  typedef struct {
    logic              status;
    logic [COST_W-1:0] total_cost;
  } cost_word_t;

  // Tracks matrices, permutations and size, and holds the costs still owed.
  class cost_scoreboard;
    logic [VAL_W-1:0]  dist_mem [MAX_SIZE][MAX_SIZE];
    logic [VAL_W-1:0]  flow_mem [MAX_SIZE][MAX_SIZE];
    bit                dist_set [MAX_SIZE][MAX_SIZE];
    bit                flow_set [MAX_SIZE][MAX_SIZE];
    logic [IDX_W-1:0]  perm [MAX_SIZE];
    logic [IDX_W-1:0]  inv_perm [MAX_SIZE];
    logic [SIZE_W-1:0] size_reg;
    cost_word_t        owed_q [$];
    int                errors;
    int                result_count;

    function new();
      for (int i = 0; i < MAX_SIZE; i++) begin
        for (int j = 0; j < MAX_SIZE; j++) begin
          dist_mem[i][j] = '0;
          flow_mem[i][j] = '0;
          dist_set[i][j] = 1'b0;
          flow_set[i][j] = 1'b0;
        end
      end
      restore_identity();
      size_reg     = SIZE_W'(MAX_SIZE);
      errors       = 0;
      result_count = 0;
    endfunction

    function void set_size(logic [SIZE_W-1:0] value);
      size_reg = value;
    endfunction

    // Effective size: zero acts as one, anything past the limit as the limit.
    function int span();
      if (size_reg == 0) return 1;
      if (size_reg > MAX_SIZE) return MAX_SIZE;
      return int'(size_reg);
    endfunction

    function void restore_identity();
      for (int k = 0; k < MAX_SIZE; k++) begin
        perm[k]     = IDX_W'(k);
        inv_perm[k] = IDX_W'(k);
      end
    endfunction

    function void exchange_positions(int a, int b);
      logic [IDX_W-1:0] va;
      logic [IDX_W-1:0] vb;
      va = perm[a];
      vb = perm[b];
      inv_perm[va] = IDX_W'(b);
      inv_perm[vb] = IDX_W'(a);
      perm[a] = vb;
      perm[b] = va;
    endfunction

    function logic [COST_W-1:0] objective();
      longint unsigned sum;
      longint unsigned cap;
      int n;
      n   = span();
      cap = (64'd1 << COST_W) - 1;
      sum = 0;
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < n; j++) begin
          sum += longint'(dist_mem[i][j]) * longint'(flow_mem[perm[i]][perm[j]]);
          if (sum > cap) sum = cap;
        end
      end
      return sum[COST_W-1:0];
    endfunction

    // First matrix entry an evaluation at the current size would read unwritten.
    function bit find_gap(output bit in_flow, output int row, output int col);
      int n;
      n = span();
      for (int i = 0; i < n; i++) begin
        for (int j = 0; j < n; j++) begin
          if (!dist_set[i][j]) begin
            in_flow = 1'b0;
            row = i;
            col = j;
            return 1'b1;
          end
          if (!flow_set[perm[i]][perm[j]]) begin
            in_flow = 1'b1;
            row = int'(perm[i]);
            col = int'(perm[j]);
            return 1'b1;
          end
        end
      end
      return 1'b0;
    endfunction

    // Apply one accepted word and queue the result it owes.
    function void note_word(op_word_t w);
      cost_word_t owed;
      int a;
      int b;
      int n;
      a = int'(w.first_index);
      b = int'(w.second_index);
      n = span();
      owed.status     = qapce_pkg::STATUS_DONE;
      owed.total_cost = '0;
      case (w.kind)
        qapce_pkg::KIND_LOAD_DIST, qapce_pkg::KIND_LOAD_FLOW: begin
          if (a >= n || b >= n) begin
            owed.status = qapce_pkg::STATUS_IGNORED;
          end else if (w.kind == qapce_pkg::KIND_LOAD_DIST) begin
            dist_mem[a][b] = w.entry_value;
            dist_set[a][b] = 1'b1;
          end else begin
            flow_mem[a][b] = w.entry_value;
            flow_set[a][b] = 1'b1;
          end
        end
        qapce_pkg::KIND_IDENTITY: restore_identity();
        qapce_pkg::KIND_SWAP: begin
          if (a >= n || b >= n) owed.status = qapce_pkg::STATUS_IGNORED;
          else exchange_positions(a, b);
        end
        qapce_pkg::KIND_ASSIGN: begin
          if (a >= n || b >= n) owed.status = qapce_pkg::STATUS_IGNORED;
          else exchange_positions(a, int'(inv_perm[b]));
        end
        qapce_pkg::KIND_EVAL: owed.total_cost = objective();
        default: owed.status = qapce_pkg::STATUS_IGNORED;
      endcase
      owed_q.push_back(owed);
    endfunction

    function void check_result(cost_word_t got);
      cost_word_t owed;
      result_count++;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("%0t: result %0d arrived with nothing owed: status %0b cost %0d",
                   $time, result_count, got.status, got.total_cost);
        return;
      end
      owed = owed_q.pop_front();
      if (got.status !== owed.status || got.total_cost !== owed.total_cost) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display({"%0t: result %0d differs: expected status %0b cost %0d, ",
                    "got status %0b cost %0d"},
                   $time, result_count, owed.status, owed.total_cost,
                   got.status, got.total_cost);
      end
    endfunction

    function int pending();
      return owed_q.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_wr_en = 1'b0;
  logic [SIZE_W-1:0]   cfg_wr_data = '0;
  bit                  hold_request = 1'b0;
  bit                  hold_done = 1'b0;
  int                  burst_left = 0;
  int                  cycle_count = 0;
  cost_word_t          seen_word;
  cost_scoreboard      sb = new();

  qapce_in_if  in_chan ();
  qapce_out_if out_chan ();

  qap_permutation_cost_engine i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #4 clk = ~clk;

  // Run-length guard.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("qap_permutation_cost_engine: mismatch");
      $finish;
    end
  end

  // Every accepted result word is checked against the oldest owed one.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid && out_chan.ready) begin
      seen_word.status     = out_chan.status;
      seen_word.total_cost = out_chan.total_cost;
      sb.check_result(seen_word);
    end
  end

  // Result side: stall patterns picked at random, each held for a random run, plus
  // one long hold-off when the stimulus asks for it.
  initial begin
    int mode;
    int mode_left;
    int tick;
    mode = 0;
    mode_left = 0;
    tick = 0;
    out_chan.ready = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (hold_request && !hold_done) begin
        out_chan.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_done = 1'b1;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(16, 80);
      end
      mode_left--;
      tick++;
      case (mode)
        0: out_chan.ready = 1'b1;
        1: out_chan.ready = 1'($urandom_range(0, 1));
        2: out_chan.ready = (tick % 4 == 0);
        default: out_chan.ready = ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  // Offer one word in bursts with random gaps, wait for acceptance, log it.
  task automatic send_word(input logic [KIND_W-1:0] kind, input int a, input int b,
                           input logic [VAL_W-1:0] value);
    op_word_t w;
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_chan.valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 10);
    end
    burst_left--;
    w.kind         = kind;
    w.first_index  = IDX_W'(a);
    w.second_index = IDX_W'(b);
    w.entry_value  = value;
    @(negedge clk);
    in_chan.valid        = 1'b1;
    in_chan.kind         = w.kind;
    in_chan.first_index  = w.first_index;
    in_chan.second_index = w.second_index;
    in_chan.entry_value  = w.entry_value;
    do @(posedge clk); while (!in_chan.ready);
    sb.note_word(w);
  endtask

  // Stop offering and let every owed result come back.
  task automatic wait_idle();
    @(negedge clk);
    in_chan.valid = 1'b0;
    burst_left = 0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_size(input logic [SIZE_W-1:0] value);
    wait_idle();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.set_size(value);
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return VAL_W'($urandom);
  endfunction

  function automatic int pick_index(input int n, input bit outside);
    if (outside && n < MAX_SIZE) return $urandom_range(n, MAX_SIZE - 1);
    return $urandom_range(0, n - 1);
  endfunction

  // Write every matrix entry inside the current size that is still unwritten.
  task automatic fill_matrices(input int n);
    for (int i = 0; i < n; i++) begin
      for (int j = 0; j < n; j++) begin
        if (!sb.dist_set[i][j]) send_word(qapce_pkg::KIND_LOAD_DIST, i, j, pick_value());
        if (!sb.flow_set[i][j]) send_word(qapce_pkg::KIND_LOAD_FLOW, i, j, pick_value());
      end
    end
  endtask

  // One random word, mostly well formed. An evaluation that would read an
  // unwritten entry is turned into a load of that entry, or into identity
  // when the entry lies outside the current size.
  task automatic random_word(input int n);
    int r;
    int sel;
    int row;
    int col;
    bit in_flow;
    bit bad;
    logic [KIND_W-1:0] kind;
    r = $urandom_range(0, 99);
    if (r < 30) begin
      kind = $urandom_range(0, 1) ? qapce_pkg::KIND_LOAD_FLOW : qapce_pkg::KIND_LOAD_DIST;
      send_word(kind, pick_index(n, 0), pick_index(n, 0), pick_value());
    end else if (r < 36) begin
      kind = $urandom_range(0, 1) ? qapce_pkg::KIND_LOAD_FLOW : qapce_pkg::KIND_LOAD_DIST;
      sel = $urandom_range(0, 2);
      send_word(kind, pick_index(n, sel != 1), pick_index(n, sel != 0), pick_value());
    end else if (r < 42) begin
      send_word(qapce_pkg::KIND_IDENTITY, $urandom_range(0, 31), $urandom_range(0, 31),
                pick_value());
    end else if (r < 74) begin
      kind = (r < 58) ? qapce_pkg::KIND_SWAP : qapce_pkg::KIND_ASSIGN;
      bad = ($urandom_range(0, 6) == 0);
      sel = $urandom_range(0, 2);
      send_word(kind, pick_index(n, bad && sel != 1), pick_index(n, bad && sel != 0),
                pick_value());
    end else if (r < 96) begin
      if (sb.find_gap(in_flow, row, col)) begin
        if (row < n && col < n)
          send_word(in_flow ? qapce_pkg::KIND_LOAD_FLOW : qapce_pkg::KIND_LOAD_DIST,
                    row, col, pick_value());
        else
          send_word(qapce_pkg::KIND_IDENTITY, $urandom_range(0, 31),
                    $urandom_range(0, 31), pick_value());
      end else begin
        send_word(qapce_pkg::KIND_EVAL, $urandom_range(0, 31), $urandom_range(0, 31),
                  pick_value());
      end
    end else begin
      kind = $urandom_range(0, 1) ? KIND_SPARE_HI : KIND_SPARE_LO;
      send_word(kind, $urandom_range(0, 31), $urandom_range(0, 31), pick_value());
    end
  endtask

  // Main stimulus.
  initial begin
    int phase_sizes [10];
    int n;
    phase_sizes = '{4, 6, 3, 1, 0, 8, 5, 2, 63, 32};
    in_chan.valid        = 1'b0;
    in_chan.kind         = '0;
    in_chan.first_index  = '0;
    in_chan.second_index = '0;
    in_chan.entry_value  = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed words at the reset size: corner indices, self swaps, rejects.
    send_word(qapce_pkg::KIND_LOAD_DIST, 31, 31, 16'hFFFF);
    send_word(qapce_pkg::KIND_LOAD_FLOW, 0, 31, 16'h0000);
    send_word(qapce_pkg::KIND_SWAP, 0, 31, 16'hFFFF);
    send_word(qapce_pkg::KIND_SWAP, 7, 7, 16'h0000);
    send_word(qapce_pkg::KIND_ASSIGN, 31, 0, 16'h0000);
    send_word(qapce_pkg::KIND_ASSIGN, 3, 31, 16'hFFFF);
    send_word(qapce_pkg::KIND_IDENTITY, 31, 31, 16'hFFFF);
    send_word(KIND_SPARE_LO, 31, 31, 16'hFFFF);
    send_word(KIND_SPARE_HI, 0, 0, 16'h0000);

    // Size two: largest entries everywhere, range checks, swap and assign.
    write_size(SIZE_W'(2));
    for (int i = 0; i < 2; i++) begin
      for (int j = 0; j < 2; j++) begin
        send_word(qapce_pkg::KIND_LOAD_DIST, i, j, 16'hFFFF);
        send_word(qapce_pkg::KIND_LOAD_FLOW, i, j, 16'hFFFF);
      end
    end
    send_word(qapce_pkg::KIND_EVAL, 0, 0, 16'h0000);
    send_word(qapce_pkg::KIND_LOAD_DIST, 2, 0, 16'h1234);
    send_word(qapce_pkg::KIND_SWAP, 0, 31, 16'h0000);
    send_word(qapce_pkg::KIND_ASSIGN, 1, 5, 16'h0000);
    send_word(qapce_pkg::KIND_SWAP, 0, 1, 16'h0000);
    send_word(qapce_pkg::KIND_LOAD_FLOW, 0, 1, 16'h0000);
    send_word(qapce_pkg::KIND_ASSIGN, 0, 0, 16'h0000);
    send_word(qapce_pkg::KIND_EVAL, 31, 31, 16'hFFFF);

    // Random phases; the permutation is carried across size changes.
    for (int p = 0; p < 10; p++) begin
      write_size(SIZE_W'(phase_sizes[p]));
      n = sb.span();
      if (n <= 8) fill_matrices(n);
      if (p == 2) hold_request = 1'b1;
      for (int k = 0; k < PHASE_WORDS; k++) random_word(n);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("qap_permutation_cost_engine: match");
    end else begin
      $display("qap_permutation_cost_engine: mismatch");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/qapce_pkg.sv
rtl/qapce_if.sv
rtl/qap_permutation_cost_engine.sv
test/tb_qap_permutation_cost_engine.sv
